// ===== hdl/tcp_flow_statistics_table_unit_defines.svh =====
// Assertion macros used by the back part of the flow statistics table.
`ifndef TCP_FLOW_STATISTICS_TABLE_UNIT_DEFINES_SVH
`define TCP_FLOW_STATISTICS_TABLE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TFST_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TFST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/tfst_pkg.sv =====
// Package with types, constants and helper functions of the flow statistics table.
package tfst_pkg;

  localparam int unsigned TableEntriesDefault = 64;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned ConnW = 6;

  localparam logic [7:0] FlagFin = 8'h01;
  localparam logic [7:0] FlagSyn = 8'h02;
  localparam logic [7:0] FlagRst = 8'h04;

  typedef enum logic [2:0] {
    ST_NEW    = 3'd0,
    ST_FWD    = 3'd1,
    ST_REV    = 3'd2,
    ST_FULL   = 3'd3,
    ST_UNUSED = 3'd4,
    ST_READ   = 3'd5
  } status_e;

  typedef struct packed {
    status_e           status;
    logic [ConnW-1:0]  conn;
    logic [7:0]        flags;
    logic [15:0]       win;
    logic [15:0]       len;
    logic [31:0]       ts;
  } req_t;

  typedef struct packed {
    logic [7:0]  syn;
    logic [7:0]  fin;
    logic [7:0]  rst;
    logic [23:0] pkt_fwd;
    logic [23:0] pkt_rev;
    logic [31:0] byte_fwd;
    logic [31:0] byte_rev;
    logic [15:0] win_lo;
    logic [15:0] win_hi;
    logic [31:0] t_first;
    logic [31:0] t_last;
  } stats_t;

  function automatic logic [7:0] sat_inc8(logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  function automatic logic [23:0] sat_inc24(logic [23:0] v);
    return (v == 24'hFFFFFF) ? v : v + 24'd1;
  endfunction

  function automatic logic [31:0] sat_add32(logic [31:0] a, logic [15:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[32] ? 32'hFFFFFFFF : s[31:0];
  endfunction

  function automatic stats_t count_flags(stats_t s, logic [7:0] f);
    stats_t r;
    r = s;
    if ((f & FlagFin) != 8'd0) begin
      r.fin = sat_inc8(s.fin);
    end else if ((f & FlagSyn) != 8'd0) begin
      r.syn = sat_inc8(s.syn);
    end else if ((f & FlagRst) != 8'd0) begin
      r.rst = sat_inc8(s.rst);
    end
    return r;
  endfunction

endpackage

// ===== hdl/tcp_flow_statistics_table_unit.sv =====
// Top level of the TCP flow statistics table.
// Requests arrive on in_valid_i/in_ready_o with one field per port. A request
// either processes one packet (cmd_i low) or reads one entry (cmd_i high).
// Every request gives exactly one result on out_valid_o/out_ready_i, in order.
// The front matches the four-tuple against all stored keys combinationally and
// allocates new entries; a two-entry request queue feeds the back, which does
// one read-modify-write of the statistics memory per request.
// The result is registered; an accepted request passes the queue, the memory
// read and the update state first. The back pops no new request until the
// update is done, since the single memory port serves both read and write.
// Reset clears the entry count and all control state; stored keys and
// statistics need no clearing, since only allocated entries are ever used.
// When the receiver stalls the result is held, the back reads the next
// request and waits with its update, and the front keeps accepting until the
// queue is full.
module tcp_flow_statistics_table_unit #(
  parameter int unsigned TableEntries = tfst_pkg::TableEntriesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [31:0] src_ip_i,
  input  logic [31:0] dst_ip_i,
  input  logic [15:0] src_port_i,
  input  logic [15:0] dst_port_i,
  input  logic [7:0]  tcp_flags_i,
  input  logic [15:0] window_i,
  input  logic [15:0] payload_len_i,
  input  logic [31:0] timestamp_us_i,
  input  logic [5:0]  read_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  conn_index_o,
  output logic [2:0]  status_o,
  output logic [7:0]  syn_seen_o,
  output logic [7:0]  fin_seen_o,
  output logic [7:0]  rst_seen_o,
  output logic [23:0] packets_fwd_o,
  output logic [23:0] packets_rev_o,
  output logic [31:0] bytes_fwd_o,
  output logic [31:0] bytes_rev_o,
  output logic [15:0] win_min_o,
  output logic [15:0] win_max_o,
  output logic [31:0] duration_us_o
);
  import tfst_pkg::*;

  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned QW = $bits(req_t) + IdxW;

  logic            push, not_full, pop, not_empty;
  req_t            f_req, b_req;
  logic [IdxW-1:0] f_addr, b_addr;
  logic [QW-1:0]   q_out;

  tfst_front #(
    .TableEntries(TableEntries),
    .IdxW(IdxW)
  ) u_front (
    .clk_i,
    .rst_ni,
    .valid_i(in_valid_i),
    .ready_o(in_ready_o),
    .cmd_i,
    .src_ip_i,
    .dst_ip_i,
    .src_port_i,
    .dst_port_i,
    .tcp_flags_i,
    .window_i,
    .payload_len_i,
    .timestamp_us_i,
    .read_index_i,
    .push_o(push),
    .req_o(f_req),
    .addr_o(f_addr),
    .not_full_i(not_full)
  );

  tfst_queue #(
    .Width(QW),
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i(push),
    .push_data_i({f_req, f_addr}),
    .not_full_o(not_full),
    .pop_i(pop),
    .pop_data_o(q_out),
    .not_empty_o(not_empty)
  );

  assign b_req  = q_out[QW-1:IdxW];
  assign b_addr = q_out[IdxW-1:0];

  tfst_back #(
    .TableEntries(TableEntries),
    .IdxW(IdxW)
  ) u_back (
    .clk_i,
    .rst_ni,
    .not_empty_i(not_empty),
    .req_i(b_req),
    .addr_i(b_addr),
    .pop_o(pop),
    .out_valid_o,
    .out_ready_i,
    .conn_index_o,
    .status_o,
    .syn_seen_o,
    .fin_seen_o,
    .rst_seen_o,
    .packets_fwd_o,
    .packets_rev_o,
    .bytes_fwd_o,
    .bytes_rev_o,
    .win_min_o,
    .win_max_o,
    .duration_us_o
  );

endmodule

// ===== hdl/tfst_queue.sv =====
// Short request queue between the classifying front and the updating back.
module tfst_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             not_full_o,
  input  logic             pop_i,
  output logic [Width-1:0] pop_data_o,
  output logic             not_empty_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign not_full_o  = (cnt_q != CntW'(Depth));
  assign not_empty_o = (cnt_q != '0);
  assign pop_data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ===== hdl/tfst_front.sv =====
// Front part: accepts requests, matches the four-tuple against all keys and allocates entries.
module tfst_front #(
  parameter int unsigned TableEntries = tfst_pkg::TableEntriesDefault,
  parameter int unsigned IdxW = $clog2(TableEntries)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic             cmd_i,
  input  logic [31:0]      src_ip_i,
  input  logic [31:0]      dst_ip_i,
  input  logic [15:0]      src_port_i,
  input  logic [15:0]      dst_port_i,
  input  logic [7:0]       tcp_flags_i,
  input  logic [15:0]      window_i,
  input  logic [15:0]      payload_len_i,
  input  logic [31:0]      timestamp_us_i,
  input  logic [5:0]       read_index_i,
  output logic             push_o,
  output tfst_pkg::req_t   req_o,
  output logic [IdxW-1:0]  addr_o,
  input  logic             not_full_i
);
  import tfst_pkg::*;

  localparam int unsigned CntW = $clog2(TableEntries + 1);
  localparam int unsigned CmpW = (CntW > ConnW) ? CntW : ConnW;

  typedef struct packed {
    logic [31:0] sip;
    logic [31:0] dip;
    logic [15:0] sp;
    logic [15:0] dp;
  } key_t;

  key_t            keys_q [TableEntries];
  logic [CntW-1:0] used_q, used_d;
  logic            fire;
  logic            hit;
  logic            hit_rev;
  logic [IdxW-1:0] hit_idx;
  logic [CmpW-1:0] ridx_ext;
  logic [CmpW-1:0] idx_ext;
  logic            full;
  logic            alloc;

  assign ready_o  = not_full_i;
  assign fire     = valid_i && not_full_i;
  assign push_o   = fire;
  assign full     = (used_q == CntW'(TableEntries));
  assign ridx_ext = CmpW'(read_index_i);

  always_comb begin
    logic f;
    logic r;
    hit     = 1'b0;
    hit_rev = 1'b0;
    hit_idx = '0;
    for (int e = TableEntries - 1; e >= 0; e--) begin
      f = keys_q[e].sip == src_ip_i && keys_q[e].dip == dst_ip_i &&
          keys_q[e].sp == src_port_i && keys_q[e].dp == dst_port_i;
      r = keys_q[e].sip == dst_ip_i && keys_q[e].dip == src_ip_i &&
          keys_q[e].sp == dst_port_i && keys_q[e].dp == src_port_i;
      if ((CntW'(e) < used_q) && (f || r)) begin
        hit     = 1'b1;
        hit_rev = r;
        hit_idx = IdxW'(e);
      end
    end
  end

  always_comb begin
    req_o.flags  = tcp_flags_i;
    req_o.win    = window_i;
    req_o.len    = payload_len_i;
    req_o.ts     = timestamp_us_i;
    req_o.status = ST_NEW;
    addr_o       = used_q[IdxW-1:0];
    alloc        = 1'b0;
    if (cmd_i) begin
      addr_o       = ridx_ext[IdxW-1:0];
      req_o.status = (ridx_ext < CmpW'(used_q)) ? ST_READ : ST_UNUSED;
    end else if (hit) begin
      addr_o       = hit_idx;
      req_o.status = hit_rev ? ST_REV : ST_FWD;
    end else if (full) begin
      addr_o       = '0;
      req_o.status = ST_FULL;
    end else begin
      alloc = 1'b1;
    end
    idx_ext    = CmpW'(addr_o);
    req_o.conn = cmd_i ? read_index_i : idx_ext[ConnW-1:0];
  end

  assign used_d = (fire && alloc) ? used_q + CntW'(1) : used_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      used_q <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && alloc) begin
      keys_q[used_q[IdxW-1:0]] <= '{sip: src_ip_i, dip: dst_ip_i,
                                    sp: src_port_i, dp: dst_port_i};
    end
  end

endmodule

// ===== hdl/tfst_back.sv =====
// Back part: read-modify-write of the statistics memory and the registered result.
`include "tcp_flow_statistics_table_unit_defines.svh"
module tfst_back #(
  parameter int unsigned TableEntries = tfst_pkg::TableEntriesDefault,
  parameter int unsigned IdxW = $clog2(TableEntries)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             not_empty_i,
  input  tfst_pkg::req_t   req_i,
  input  logic [IdxW-1:0]  addr_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [5:0]       conn_index_o,
  output logic [2:0]       status_o,
  output logic [7:0]       syn_seen_o,
  output logic [7:0]       fin_seen_o,
  output logic [7:0]       rst_seen_o,
  output logic [23:0]      packets_fwd_o,
  output logic [23:0]      packets_rev_o,
  output logic [31:0]      bytes_fwd_o,
  output logic [31:0]      bytes_rev_o,
  output logic [15:0]      win_min_o,
  output logic [15:0]      win_max_o,
  output logic [31:0]      duration_us_o
);
  import tfst_pkg::*;

  localparam logic SIdle = 1'b0;
  localparam logic SCalc = 1'b1;

  stats_t          mem_q [TableEntries];
  stats_t          rd_q;
  req_t            req_q;
  logic [IdxW-1:0] addr_q;
  logic            state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            calc_fire;
  logic            wr_en;
  stats_t          upd;
  stats_t          res;
  logic            show;
  stats_t          out_q;
  logic            show_q;
  logic [5:0]      conn_q;
  status_e         status_q;

  assign pop_o     = (state_q == SIdle) && not_empty_i;
  assign calc_fire = (state_q == SCalc) && (!out_valid_q || out_ready_i);

  always_comb begin
    upd   = rd_q;
    wr_en = 1'b0;
    show  = 1'b1;
    unique case (req_q.status)
      ST_NEW: begin
        upd = '{syn: 8'd0, fin: 8'd0, rst: 8'd0, pkt_fwd: 24'd1, pkt_rev: 24'd0,
                byte_fwd: {16'd0, req_q.len}, byte_rev: 32'd0,
                win_lo: req_q.win, win_hi: req_q.win,
                t_first: req_q.ts, t_last: req_q.ts};
        upd   = count_flags(upd, req_q.flags);
        wr_en = 1'b1;
      end
      ST_FWD, ST_REV: begin
        upd        = count_flags(rd_q, req_q.flags);
        upd.t_last = req_q.ts;
        if (req_q.status == ST_REV) begin
          upd.pkt_rev  = sat_inc24(rd_q.pkt_rev);
          upd.byte_rev = sat_add32(rd_q.byte_rev, req_q.len);
        end else begin
          upd.pkt_fwd  = sat_inc24(rd_q.pkt_fwd);
          upd.byte_fwd = sat_add32(rd_q.byte_fwd, req_q.len);
        end
        if (req_q.win > rd_q.win_hi) begin
          upd.win_hi = req_q.win;
        end
        if (req_q.win < rd_q.win_lo) begin
          upd.win_lo = req_q.win;
        end
        wr_en = 1'b1;
      end
      ST_READ: begin
        upd = rd_q;
      end
      default: begin
        show = 1'b0;
      end
    endcase
    res = upd;
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      SIdle: begin
        if (pop_o) begin
          state_d = SCalc;
        end
      end
      SCalc: begin
        if (calc_fire) begin
          state_d     = SIdle;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rd_q   <= mem_q[addr_i];
      req_q  <= req_i;
      addr_q <= addr_i;
    end
    if (calc_fire && wr_en) begin
      mem_q[addr_q] <= res;
    end
    if (calc_fire) begin
      out_q    <= res;
      show_q   <= show;
      conn_q   <= req_q.conn;
      status_q <= req_q.status;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign conn_index_o  = conn_q;
  assign status_o      = status_q;
  assign syn_seen_o    = show_q ? out_q.syn : 8'd0;
  assign fin_seen_o    = show_q ? out_q.fin : 8'd0;
  assign rst_seen_o    = show_q ? out_q.rst : 8'd0;
  assign packets_fwd_o = show_q ? out_q.pkt_fwd : 24'd0;
  assign packets_rev_o = show_q ? out_q.pkt_rev : 24'd0;
  assign bytes_fwd_o   = show_q ? out_q.byte_fwd : 32'd0;
  assign bytes_rev_o   = show_q ? out_q.byte_rev : 32'd0;
  assign win_min_o     = show_q ? out_q.win_lo : 16'd0;
  assign win_max_o     = show_q ? out_q.win_hi : 16'd0;
  assign duration_us_o = show_q ? (out_q.t_last - out_q.t_first) : 32'd0;

  `TFST_ASSERT_NEXT(a_pop_to_calc, pop_o, state_q == SCalc, "Request popped without update cycle.")
  `TFST_ASSERT_NEXT(a_calc_gives_result, calc_fire, out_valid_q && state_q == SIdle, "Update gave no result.")
  `TFST_ASSERT_SAME(a_no_pop_in_calc, state_q == SCalc, !pop_o, "Request popped during update.")
  `TFST_ASSERT_NEXT(a_stall_holds, state_q == SCalc && !calc_fire, state_q == SCalc && $stable(addr_q), "Stalled update lost its request.")

endmodule

// ===== verif/tcp_flow_statistics_table_checker.sv =====
// Checker that predicts and compares the results of the flow statistics table.
module tcp_flow_statistics_table_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        cmd_i,
  input  logic [31:0] src_ip_i,
  input  logic [31:0] dst_ip_i,
  input  logic [15:0] src_port_i,
  input  logic [15:0] dst_port_i,
  input  logic [7:0]  tcp_flags_i,
  input  logic [15:0] window_i,
  input  logic [15:0] payload_len_i,
  input  logic [31:0] timestamp_us_i,
  input  logic [5:0]  read_index_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [5:0]  conn_index_i,
  input  logic [2:0]  status_i,
  input  logic [7:0]  syn_seen_i,
  input  logic [7:0]  fin_seen_i,
  input  logic [7:0]  rst_seen_i,
  input  logic [23:0] packets_fwd_i,
  input  logic [23:0] packets_rev_i,
  input  logic [31:0] bytes_fwd_i,
  input  logic [31:0] bytes_rev_i,
  input  logic [15:0] win_min_i,
  input  logic [15:0] win_max_i,
  input  logic [31:0] duration_us_i,
  output int          fail_count_o,
  output int          pending_count_o
);
  import tfst_pkg::*;

  localparam int unsigned Entries = TableEntriesDefault;

  typedef struct packed {
    logic [5:0]  conn;
    status_e     status;
    logic [7:0]  syn;
    logic [7:0]  fin;
    logic [7:0]  rst;
    logic [23:0] pkt_fwd;
    logic [23:0] pkt_rev;
    logic [31:0] byte_fwd;
    logic [31:0] byte_rev;
    logic [15:0] win_lo;
    logic [15:0] win_hi;
    logic [31:0] duration;
  } flow_report_t;

  logic [31:0] key_sip [Entries];
  logic [31:0] key_dip [Entries];
  logic [15:0] key_sp [Entries];
  logic [15:0] key_dp [Entries];
  logic [7:0]  cnt_syn [Entries];
  logic [7:0]  cnt_fin [Entries];
  logic [7:0]  cnt_rst [Entries];
  logic [23:0] cnt_pf [Entries];
  logic [23:0] cnt_pr [Entries];
  logic [31:0] cnt_bf [Entries];
  logic [31:0] cnt_br [Entries];
  logic [15:0] win_lo [Entries];
  logic [15:0] win_hi [Entries];
  logic [31:0] t_first [Entries];
  logic [31:0] t_last [Entries];
  int unsigned flows_used;

  flow_report_t expected_reports[$];
  int mismatches;

  assign fail_count_o = mismatches;
  assign pending_count_o = expected_reports.size();

  function automatic logic [31:0] add_sat32(logic [31:0] a, logic [15:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic void tally_flags(int e, logic [7:0] f);
    if (f[0]) begin
      if (cnt_fin[e] != 8'hFF) cnt_fin[e] = cnt_fin[e] + 8'd1;
    end else if (f[1]) begin
      if (cnt_syn[e] != 8'hFF) cnt_syn[e] = cnt_syn[e] + 8'd1;
    end else if (f[2]) begin
      if (cnt_rst[e] != 8'hFF) cnt_rst[e] = cnt_rst[e] + 8'd1;
    end
  endfunction

  function automatic flow_report_t entry_report(int e, logic [5:0] idx, status_e st);
    flow_report_t r;
    r = '0;
    r.conn = idx;
    r.status = st;
    r.syn = cnt_syn[e];
    r.fin = cnt_fin[e];
    r.rst = cnt_rst[e];
    r.pkt_fwd = cnt_pf[e];
    r.pkt_rev = cnt_pr[e];
    r.byte_fwd = cnt_bf[e];
    r.byte_rev = cnt_br[e];
    r.win_lo = win_lo[e];
    r.win_hi = win_hi[e];
    r.duration = t_last[e] - t_first[e];
    return r;
  endfunction

  function automatic flow_report_t update_flow_table();
    flow_report_t r;
    logic fwd;
    logic rev;
    int e;
    r = '0;
    if (cmd_i) begin
      if (read_index_i < flows_used) return entry_report(read_index_i, read_index_i, ST_READ);
      r.conn = read_index_i;
      r.status = ST_UNUSED;
      return r;
    end
    for (e = 0; e < flows_used; e++) begin
      fwd = key_sip[e] == src_ip_i && key_dip[e] == dst_ip_i &&
            key_sp[e] == src_port_i && key_dp[e] == dst_port_i;
      rev = key_sip[e] == dst_ip_i && key_dip[e] == src_ip_i &&
            key_sp[e] == dst_port_i && key_dp[e] == src_port_i;
      if (fwd || rev) begin
        tally_flags(e, tcp_flags_i);
        t_last[e] = timestamp_us_i;
        if (rev) begin
          if (cnt_pr[e] != 24'hFF_FFFF) cnt_pr[e] = cnt_pr[e] + 24'd1;
          cnt_br[e] = add_sat32(cnt_br[e], payload_len_i);
        end else begin
          if (cnt_pf[e] != 24'hFF_FFFF) cnt_pf[e] = cnt_pf[e] + 24'd1;
          cnt_bf[e] = add_sat32(cnt_bf[e], payload_len_i);
        end
        if (window_i > win_hi[e]) win_hi[e] = window_i;
        if (window_i < win_lo[e]) win_lo[e] = window_i;
        return entry_report(e, e[5:0], rev ? ST_REV : ST_FWD);
      end
    end
    if (flows_used >= Entries) begin
      r.status = ST_FULL;
      return r;
    end
    e = flows_used;
    key_sip[e] = src_ip_i;
    key_dip[e] = dst_ip_i;
    key_sp[e] = src_port_i;
    key_dp[e] = dst_port_i;
    cnt_syn[e] = '0;
    cnt_fin[e] = '0;
    cnt_rst[e] = '0;
    tally_flags(e, tcp_flags_i);
    cnt_pf[e] = 24'd1;
    cnt_pr[e] = '0;
    cnt_bf[e] = {16'd0, payload_len_i};
    cnt_br[e] = '0;
    win_lo[e] = window_i;
    win_hi[e] = window_i;
    t_first[e] = timestamp_us_i;
    t_last[e] = timestamp_us_i;
    flows_used = e + 1;
    return entry_report(e, e[5:0], ST_NEW);
  endfunction

  task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
    $display("mismatch on %s: got %0h, expected %0h at %0t", field, got, want, $realtime);
    mismatches++;
  endtask

  initial begin
    mismatches = 0;
    flows_used = 0;
  end

  always @(posedge clk_i) begin
    flow_report_t want;
    if (rst_ni && in_valid_i && in_ready_i) expected_reports.push_back(update_flow_table());
    if (rst_ni && out_valid_i && out_ready_i) begin
      if (expected_reports.size() == 0) begin
        report_mismatch("unexpected result", status_i, 0);
      end else begin
        want = expected_reports.pop_front();
        if (conn_index_i !== want.conn) report_mismatch("conn_index", conn_index_i, want.conn);
        if (status_i !== want.status) report_mismatch("status", status_i, want.status);
        if (syn_seen_i !== want.syn) report_mismatch("syn_seen", syn_seen_i, want.syn);
        if (fin_seen_i !== want.fin) report_mismatch("fin_seen", fin_seen_i, want.fin);
        if (rst_seen_i !== want.rst) report_mismatch("rst_seen", rst_seen_i, want.rst);
        if (packets_fwd_i !== want.pkt_fwd)
          report_mismatch("packets_fwd", packets_fwd_i, want.pkt_fwd);
        if (packets_rev_i !== want.pkt_rev)
          report_mismatch("packets_rev", packets_rev_i, want.pkt_rev);
        if (bytes_fwd_i !== want.byte_fwd) report_mismatch("bytes_fwd", bytes_fwd_i, want.byte_fwd);
        if (bytes_rev_i !== want.byte_rev) report_mismatch("bytes_rev", bytes_rev_i, want.byte_rev);
        if (win_min_i !== want.win_lo) report_mismatch("win_min", win_min_i, want.win_lo);
        if (win_max_i !== want.win_hi) report_mismatch("win_max", win_max_i, want.win_hi);
        if (duration_us_i !== want.duration)
          report_mismatch("duration_us", duration_us_i, want.duration);
      end
    end
  end

endmodule

// ===== verif/testbench.sv =====
// Top of the flow statistics table testbench: stimulus, result draining and verdict.
module testbench;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        cmd_i;
  logic [31:0] src_ip_i;
  logic [31:0] dst_ip_i;
  logic [15:0] src_port_i;
  logic [15:0] dst_port_i;
  logic [7:0]  tcp_flags_i;
  logic [15:0] window_i;
  logic [15:0] payload_len_i;
  logic [31:0] timestamp_us_i;
  logic [5:0]  read_index_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [5:0]  conn_index_o;
  logic [2:0]  status_o;
  logic [7:0]  syn_seen_o;
  logic [7:0]  fin_seen_o;
  logic [7:0]  rst_seen_o;
  logic [23:0] packets_fwd_o;
  logic [23:0] packets_rev_o;
  logic [31:0] bytes_fwd_o;
  logic [31:0] bytes_rev_o;
  logic [15:0] win_min_o;
  logic [15:0] win_max_o;
  logic [31:0] duration_us_o;
  int          fail_count;
  int          pending_count;

  logic [31:0] pool_sip [72];
  logic [31:0] pool_dip [72];
  logic [15:0] pool_sp [72];
  logic [15:0] pool_dp [72];
  logic [31:0] clock_us;
  int          results_taken;

  tcp_flow_statistics_table_unit uut (.*);

  tcp_flow_statistics_table_checker checker_inst (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .cmd_i, .src_ip_i, .dst_ip_i,
    .src_port_i, .dst_port_i, .tcp_flags_i, .window_i, .payload_len_i, .timestamp_us_i,
    .read_index_i, .out_valid_i(out_valid_o), .out_ready_i, .conn_index_i(conn_index_o),
    .status_i(status_o), .syn_seen_i(syn_seen_o), .fin_seen_i(fin_seen_o),
    .rst_seen_i(rst_seen_o), .packets_fwd_i(packets_fwd_o), .packets_rev_i(packets_rev_o),
    .bytes_fwd_i(bytes_fwd_o), .bytes_rev_i(bytes_rev_o), .win_min_i(win_min_o),
    .win_max_i(win_max_o), .duration_us_i(duration_us_o),
    .fail_count_o(fail_count), .pending_count_o(pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #1000000;
    $display("== FAIL ==");
    $finish;
  end

  // Offers one request after a random gap and holds it until it is accepted.
  task automatic offer_request(logic cmd, logic [31:0] sip, logic [31:0] dip, logic [15:0] sp,
                               logic [15:0] dp, logic [7:0] flags, logic [15:0] win,
                               logic [15:0] len, logic [31:0] ts, logic [5:0] ridx);
    int gap;
    gap = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    cmd_i = cmd;
    src_ip_i = sip;
    dst_ip_i = dip;
    src_port_i = sp;
    dst_port_i = dp;
    tcp_flags_i = flags;
    window_i = win;
    payload_len_i = len;
    timestamp_us_i = ts;
    read_index_i = ridx;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic offer_packet(int k, logic swap, logic [7:0] flags);
    logic [15:0] len;
    clock_us = clock_us + $urandom_range(0, 5000);
    if ($urandom_range(0, 19) == 0) clock_us = $urandom;
    case ($urandom_range(0, 9))
      0: len = 16'd0;
      1: len = 16'hFFFF;
      default: len = 16'($urandom);
    endcase
    if (swap) begin
      offer_request(1'b0, pool_dip[k], pool_sip[k], pool_dp[k], pool_sp[k], flags,
                    16'($urandom), len, clock_us, 6'($urandom));
    end else begin
      offer_request(1'b0, pool_sip[k], pool_dip[k], pool_sp[k], pool_dp[k], flags,
                    16'($urandom), len, clock_us, 6'($urandom));
    end
  endtask

  // Drains results with random stalls and one long hold-off that fills the block.
  initial begin
    int stall;
    out_ready_i = 1'b0;
    results_taken = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = $urandom_range(0, 4);
      if (results_taken % 100 < 30) stall = 0;
      if (results_taken == 150) stall = 80;
      if (stall > 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      results_taken++;
    end
  end

  initial begin
    int k;
    logic [7:0] f;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    cmd_i = 1'b0;
    src_ip_i = '0;
    dst_ip_i = '0;
    src_port_i = '0;
    dst_port_i = '0;
    tcp_flags_i = '0;
    window_i = '0;
    payload_len_i = '0;
    timestamp_us_i = '0;
    read_index_i = '0;
    clock_us = 32'hFFFF_0000;
    for (int i = 0; i < 72; i++) begin
      pool_sip[i] = $urandom;
      pool_dip[i] = $urandom;
      pool_sp[i] = 16'($urandom);
      pool_dp[i] = 16'($urandom);
    end
    // The first flow has the same address and port at both ends.
    pool_dip[0] = pool_sip[0];
    pool_dp[0] = pool_sp[0];
    pool_sip[1] = '0;
    pool_dip[1] = 32'hFFFF_FFFF;
    pool_sp[1] = '0;
    pool_dp[1] = 16'hFFFF;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    offer_request(1'b1, '0, '0, '0, '0, '0, '0, '0, '0, 6'd0);
    offer_request(1'b0, pool_sip[1], pool_dip[1], pool_sp[1], pool_dp[1], 8'hFF, 16'hFFFF,
                  16'hFFFF, 32'hFFFF_FFFF, 6'h3F);
    offer_request(1'b0, pool_dip[1], pool_sip[1], pool_dp[1], pool_sp[1], 8'h00, 16'h0000,
                  16'hFFFF, 32'h0000_0005, 6'h00);
    offer_packet(0, 1'b0, 8'h02);
    offer_packet(0, 1'b1, 8'h01);
    offer_packet(0, 1'b0, 8'h04);
    offer_packet(1, 1'b0, 8'h06);
    offer_packet(1, 1'b1, 8'h10);
    offer_packet(2, 1'b0, 8'h03);
    offer_packet(2, 1'b1, 8'h05);
    offer_request(1'b1, '0, '0, '0, '0, '0, '0, '0, '0, 6'd1);
    offer_request(1'b1, '1, '1, '1, '1, '1, '1, '1, '1, 6'd2);
    offer_request(1'b1, '0, '0, '0, '0, '0, '0, '0, '0, 6'd3);
    offer_request(1'b1, '0, '0, '0, '0, '0, '0, '0, '0, 6'h3F);

    // A long run of SYN packets on one flow drives its counter into saturation.
    for (int i = 0; i < 262; i++) offer_packet(2, i[0], 8'h02 | (8'($urandom) & 8'hF8));

    for (int i = 0; i < 870; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        offer_request(1'b1, $urandom, $urandom, 16'($urandom), 16'($urandom), 8'($urandom),
                      16'($urandom), 16'($urandom), $urandom, 6'($urandom));
      end else if ($urandom_range(0, 19) == 0) begin
        offer_request(1'b0, $urandom, $urandom, 16'($urandom), 16'($urandom), 8'($urandom),
                      16'($urandom), 16'($urandom), $urandom, 6'($urandom));
      end else begin
        k = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 11) : $urandom_range(0, 71);
        f = 8'($urandom);
        offer_packet(k, $urandom_range(0, 9) < 4, f);
      end
    end
    in_valid_i = 1'b0;

    while (pending_count != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
